FILE: hdl/mbps_pkg.sv
// Shared constants, codes and types of the mash and boil process sequencer.
`default_nettype none
package mbps_pkg;

  localparam int MAX_STEPS        = 6;
  localparam int TICKS_PER_UNIT   = 6000;
  localparam int TICKS_PER_SECOND = 100;

  localparam int FRAC_W  = $clog2(TICKS_PER_SECOND);
  localparam int PRESC_W = $clog2(TICKS_PER_UNIT + 1);
  localparam int IDX_W   = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int LIM_W   = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [6:0] DUTY_FULL = 7'd100;
  localparam logic [5:0] SIXTY_LAST = 6'd59;
  localparam logic [7:0] ELAPSED_MAX = 8'hFF;

  typedef enum logic [2:0] {
    PH_PREPARE = 3'd0,
    PH_PREHEAT = 3'd1,
    PH_MASH    = 3'd2,
    PH_BOIL    = 3'd3,
    PH_COOL    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_LOAD = 2'd1,
    ACT_DUTY = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_COUNT       = 3'd0,
    CFG_PREHEAT_TEMP     = 3'd1,
    CFG_BOIL_DURATION    = 3'd2,
    CFG_PREBOIL_DURATION = 3'd3,
    CFG_BOIL_START_TEMP  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0] step_count;
    logic [6:0] preheat_temp;
    logic [7:0] boil_duration;
    logic [6:0] boil_start_temp;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        action;
    logic signed [9:0] temp_quarter;
    logic              continue_req;
    logic [2:0]        entry_index;
    logic [6:0]        entry_temp;
    logic [7:0]        entry_duration;
    logic [6:0]        duty_value;
  } item_t;

  typedef struct packed {
    logic [7:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       heater_on;
  } clk_res_t;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] step;
    logic [6:0] duty;
    logic [6:0] setpoint;
    logic       reached;
    logic [7:0] elapsed;
  } seq_res_t;

endpackage
`default_nettype wire

FILE: hdl/mbps_if.sv
// Request and result channel interfaces of the process sequencer.
`default_nettype none
interface mbps_item_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic signed [9:0] temp_quarter;
  logic              continue_req;
  logic [2:0]        entry_index;
  logic [6:0]        entry_temp;
  logic [7:0]        entry_duration;
  logic [6:0]        duty_value;

  modport source(output valid, action, temp_quarter, continue_req, entry_index,
                 entry_temp, entry_duration, duty_value, input ready);
  modport sink(input valid, action, temp_quarter, continue_req, entry_index,
               entry_temp, entry_duration, duty_value, output ready);
endinterface

interface mbps_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] phase;
  logic [2:0] step_now;
  logic       heater_on;
  logic [6:0] heater_duty_now;
  logic [6:0] setpoint;
  logic       target_reached;
  logic [7:0] elapsed_units;
  logic [7:0] clock_hours;
  logic [5:0] clock_minutes;
  logic [5:0] clock_seconds;

  modport source(output valid, phase, step_now, heater_on, heater_duty_now, setpoint,
                 target_reached, elapsed_units, clock_hours, clock_minutes,
                 clock_seconds, input ready);
  modport sink(input valid, phase, step_now, heater_on, heater_duty_now, setpoint,
               target_reached, elapsed_units, clock_hours, clock_minutes,
               clock_seconds, output ready);
endinterface
`default_nettype wire

FILE: hdl/mbps_cfg.sv
// Configuration register file of the process sequencer.
`default_nettype none
module mbps_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
  output mbps_pkg::cfg_t                      cfg
);

  mbps_pkg::cfg_reg_t sel;
  assign sel = mbps_pkg::cfg_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_count      <= 3'd3;
      cfg.preheat_temp    <= 7'd50;
      cfg.boil_duration   <= 8'd60;
      cfg.boil_start_temp <= 7'd98;
    end else if (cfg_we) begin
      unique case (sel)
        mbps_pkg::CFG_STEP_COUNT:      cfg.step_count      <= cfg_data[2:0];
        mbps_pkg::CFG_PREHEAT_TEMP:    cfg.preheat_temp    <= cfg_data[6:0];
        mbps_pkg::CFG_BOIL_DURATION:   cfg.boil_duration   <= cfg_data[7:0];
        mbps_pkg::CFG_BOIL_START_TEMP: cfg.boil_start_temp <= cfg_data[6:0];
        // gentle boil length is accepted but drives nothing
        mbps_pkg::CFG_PREBOIL_DURATION: ;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mbps_clock.sv
// Running h:m:s clock and slow heater PWM, advanced once per tick.
`default_nettype none
module mbps_clock (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       tick,
  input  wire logic [6:0] duty,
  output mbps_pkg::clk_res_t nx
);

  localparam int CMP_W = mbps_pkg::FRAC_W + 7;

  logic [mbps_pkg::FRAC_W-1:0] frac, frac_next;
  mbps_pkg::clk_res_t cur;
  logic wrap;

  assign wrap      = frac == mbps_pkg::FRAC_W'(mbps_pkg::TICKS_PER_SECOND - 1);
  assign frac_next = tick ? (wrap ? '0 : frac + 1'b1) : frac;

  always_comb begin
    nx = cur;
    if (tick) begin
      if (wrap) begin
        if (cur.seconds < mbps_pkg::SIXTY_LAST) begin
          nx.seconds = cur.seconds + 6'd1;
        end else begin
          nx.seconds = '0;
          if (cur.minutes < mbps_pkg::SIXTY_LAST) begin
            nx.minutes = cur.minutes + 6'd1;
          end else begin
            nx.minutes = '0;
            nx.hours   = cur.hours + 8'd1;
          end
        end
        nx.heater_on = 1'b1;
      end
      // drop the relay when the fraction meets the duty
      if (CMP_W'(frac_next) == CMP_W'(duty)) nx.heater_on = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frac <= '0;
      cur  <= '0;
    end else begin
      frac <= frac_next;
      cur  <= nx;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mbps_seq.sv
// Phase sequencer: schedule table, unit timer, duty and setpoint.
`default_nettype none
module mbps_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            tick,
  input  wire logic            load,
  input  wire logic            set_duty,
  input  mbps_pkg::item_t      item,
  input  mbps_pkg::cfg_t       cfg,
  output mbps_pkg::seq_res_t   nx_out,
  output logic [6:0]           duty_now
);

  localparam int LW = mbps_pkg::LIM_W;

  mbps_pkg::seq_res_t cur, nx;
  logic [mbps_pkg::PRESC_W-1:0] presc, presc_next, presc_inc;
  logic [14:0] sched [mbps_pkg::MAX_STEPS];
  logic [14:0] cur_entry, nx_entry;
  logic [LW-1:0] limit;
  logic signed [10:0] temp_x, step_goal, boil_goal;
  logic idx_ok;

  assign duty_now  = cur.duty;
  assign cur_entry = sched[mbps_pkg::IDX_W'(cur.step)];
  assign nx_entry  = sched[mbps_pkg::IDX_W'(nx.step)];
  assign limit     = (LW'(cfg.step_count) > LW'(mbps_pkg::MAX_STEPS)) ?
                     LW'(mbps_pkg::MAX_STEPS) : LW'(cfg.step_count);
  assign presc_inc = presc + 1'b1;
  assign temp_x    = {item.temp_quarter[9], item.temp_quarter};
  assign step_goal = $signed({2'b00, cur_entry[14:8], 2'b00});
  assign boil_goal = $signed({2'b00, cfg.boil_start_temp, 2'b00});
  assign idx_ok    = LW'(item.entry_index) < LW'(mbps_pkg::MAX_STEPS);

  always_comb begin
    nx         = cur;
    presc_next = presc;
    if (set_duty) begin
      nx.duty = (item.duty_value > mbps_pkg::DUTY_FULL) ? mbps_pkg::DUTY_FULL
                                                        : item.duty_value;
    end
    if (tick) begin
      // unit timer runs ahead of the phase decisions
      if (cur.reached) begin
        if (presc_inc == mbps_pkg::PRESC_W'(mbps_pkg::TICKS_PER_UNIT)) begin
          presc_next = '0;
          if (cur.elapsed != mbps_pkg::ELAPSED_MAX) nx.elapsed = cur.elapsed + 8'd1;
        end else begin
          presc_next = presc_inc;
        end
      end
      unique case (cur.phase)
        mbps_pkg::PH_PREHEAT: begin
          nx.setpoint = cfg.preheat_temp;
          if (item.continue_req) begin
            nx.phase   = mbps_pkg::PH_MASH;
            nx.step    = '0;
            nx.reached = 1'b0;
            nx.elapsed = '0;
            presc_next = '0;
          end
        end
        mbps_pkg::PH_MASH: begin
          if (cur.reached) begin
            if (nx.elapsed >= cur_entry[7:0]) begin
              nx.reached = 1'b0;
              nx.elapsed = '0;
              presc_next = '0;
              if (LW'(cur.step) + LW'(1) < limit) nx.step = cur.step + 3'd1;
              else nx.phase = mbps_pkg::PH_BOIL;
            end
          end else if (temp_x >= step_goal) begin
            nx.reached = 1'b1;
            nx.elapsed = '0;
            presc_next = '0;
          end
        end
        mbps_pkg::PH_BOIL: begin
          if (cur.reached) begin
            if (nx.elapsed >= cfg.boil_duration) nx.phase = mbps_pkg::PH_COOL;
          end else if (temp_x < boil_goal) begin
            nx.duty = mbps_pkg::DUTY_FULL;
          end else begin
            nx.reached = 1'b1;
            nx.elapsed = '0;
            presc_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // setpoint follows the phase the tick leaves behind
  always_comb begin
    nx_out = nx;
    if (tick && nx.phase == mbps_pkg::PH_MASH) nx_out.setpoint = nx_entry[14:8];
    else if (tick && nx.phase == mbps_pkg::PH_BOIL) nx_out.setpoint = cfg.boil_start_temp;
  end

  always_ff @(posedge clk) begin
    if (load && idx_ok) begin
      sched[mbps_pkg::IDX_W'(item.entry_index)] <= {item.entry_temp, item.entry_duration};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.phase    <= mbps_pkg::PH_PREHEAT;
      cur.step     <= '0;
      cur.duty     <= '0;
      cur.setpoint <= '0;
      cur.reached  <= 1'b0;
      cur.elapsed  <= '0;
      presc        <= '0;
    end else begin
      cur   <= nx_out;
      presc <= presc_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/mash_boil_process_sequencer.sv
// Top level of the mash and boil process sequencer.
//
//   channel   role     carries
//   item      sink     tick, schedule-entry load, duty set or no-op, with temperature
//   result    source   phase, step, heater, setpoint, timer and h:m:s clock
//   cfg_*     write    step count, preheat, boil and preboil settings
//
// One request per cycle sustained while results are taken. A request is held
// in the input register, then its state update lands in the result register.
// Reset clears the control state, phase goes to preheat; the schedule table
// is not cleared. A stalled result holds the result register and the input
// register behind it; one more request fits.
`default_nettype none
module mash_boil_process_sequencer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  mbps_item_if.sink                            item,
  mbps_result_if.source                        result,
  input  wire logic                            cfg_we,
  input  wire logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data
);

  mbps_pkg::item_t    hold;
  mbps_pkg::cfg_t     cfg;
  mbps_pkg::clk_res_t clk_nx;
  mbps_pkg::seq_res_t seq_nx;
  logic [6:0] seq_duty;
  logic hold_valid, out_free, adv, tick, load, set_duty;

  assign out_free   = !result.valid || result.ready;
  assign adv        = hold_valid && out_free;
  assign item.ready = !hold_valid || out_free;

  assign tick     = adv && hold.action == mbps_pkg::ACT_TICK;
  assign load     = adv && hold.action == mbps_pkg::ACT_LOAD;
  assign set_duty = adv && hold.action == mbps_pkg::ACT_DUTY;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item.ready) begin
      hold_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      hold.action         <= item.action;
      hold.temp_quarter   <= item.temp_quarter;
      hold.continue_req   <= item.continue_req;
      hold.entry_index    <= item.entry_index;
      hold.entry_temp     <= item.entry_temp;
      hold.entry_duration <= item.entry_duration;
      hold.duty_value     <= item.duty_value;
    end
  end

  mbps_cfg u_cfg (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg
  );

  // the relay compares against the duty held before this tick
  mbps_clock u_clock (
    .clk, .rst, .tick, .duty(seq_duty), .nx(clk_nx)
  );

  mbps_seq u_seq (
    .clk, .rst, .tick, .load, .set_duty, .item(hold), .cfg, .nx_out(seq_nx),
    .duty_now(seq_duty)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= hold_valid;
    end
    if (adv) begin
      result.phase           <= seq_nx.phase;
      result.step_now        <= seq_nx.step;
      result.heater_on       <= clk_nx.heater_on;
      result.heater_duty_now <= seq_nx.duty;
      result.setpoint        <= seq_nx.setpoint;
      result.target_reached  <= seq_nx.reached;
      result.elapsed_units   <= seq_nx.elapsed;
      result.clock_hours     <= clk_nx.hours;
      result.clock_minutes   <= clk_nx.minutes;
      result.clock_seconds   <= clk_nx.seconds;
    end
  end

`ifndef SYNTHESIS
  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> result.valid)
    else $error("request in the input register did not reach the result register");

  a_elapsed_needs_reached: assert property (@(posedge clk) disable iff (rst)
    (adv && seq_nx.elapsed != 8'd0) |-> seq_nx.reached)
    else $error("unit timer running without target reached");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    adv |-> (5'(seq_nx.step) < 5'(mbps_pkg::MAX_STEPS)))
    else $error("mash step index out of range");

  a_duty_in_range: assert property (@(posedge clk) disable iff (rst)
    adv |-> (seq_nx.duty <= mbps_pkg::DUTY_FULL))
    else $error("heater duty above full scale");
`endif

endmodule
`default_nettype wire

FILE: test/mash_boil_process_sequencer_test.sv
// Self-checking testbench of the mash and boil process sequencer: scoreboard and drivers.
module mash_boil_process_sequencer_test;

  typedef struct packed {
    logic [2:0] phase;
    logic [2:0] step;
    logic       heater;
    logic [6:0] duty;
    logic [6:0] setpoint;
    logic       reached;
    logic [7:0] elapsed;
    logic [7:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } status_t;

  class process_scoreboard;
    logic [2:0]  step_count;
    logic [6:0]  preheat_temp;
    logic [7:0]  boil_duration;
    logic [7:0]  preboil_duration;
    logic [6:0]  boil_start_temp;
    int unsigned fraction;
    int unsigned prescaler;
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [7:0]  hours;
    logic [7:0]  elapsed;
    mbps_pkg::phase_t phase;
    logic [2:0]  step;
    logic        reached;
    logic        relay;
    logic [6:0]  duty;
    logic [6:0]  setpoint;
    logic [6:0]  entry_temp [mbps_pkg::MAX_STEPS];
    logic [7:0]  entry_dur [mbps_pkg::MAX_STEPS];
    status_t     expected_status [$];
    int          mismatches;

    function new();
      step_count = 3'd3;
      preheat_temp = 7'd50;
      boil_duration = 8'd60;
      preboil_duration = 8'd3;
      boil_start_temp = 7'd98;
      fraction = 0;
      prescaler = 0;
      seconds = '0;
      minutes = '0;
      hours = '0;
      elapsed = '0;
      phase = mbps_pkg::PH_PREHEAT;
      step = '0;
      reached = 1'b0;
      relay = 1'b0;
      duty = '0;
      setpoint = '0;
      mismatches = 0;
    endfunction

    function void set_config(mbps_pkg::cfg_reg_t idx, logic [7:0] data);
      case (idx)
        mbps_pkg::CFG_STEP_COUNT:       step_count = data[2:0];
        mbps_pkg::CFG_PREHEAT_TEMP:     preheat_temp = data[6:0];
        mbps_pkg::CFG_BOIL_DURATION:    boil_duration = data;
        mbps_pkg::CFG_PREBOIL_DURATION: preboil_duration = data;
        mbps_pkg::CFG_BOIL_START_TEMP:  boil_start_temp = data[6:0];
        default: ;
      endcase
    endfunction

    function void advance_clock();
      fraction = (fraction + 1 >= mbps_pkg::TICKS_PER_SECOND) ? 0 : fraction + 1;
      if (fraction == 0) begin
        if (seconds < mbps_pkg::SIXTY_LAST) begin
          seconds++;
        end else begin
          seconds = '0;
          if (minutes < mbps_pkg::SIXTY_LAST) begin
            minutes++;
          end else begin
            minutes = '0;
            hours++;
          end
        end
        relay = 1'b1;
      end
      if (fraction == duty) relay = 1'b0;
      if (reached) begin
        prescaler++;
        if (prescaler >= mbps_pkg::TICKS_PER_UNIT) begin
          prescaler = 0;
          if (elapsed != mbps_pkg::ELAPSED_MAX) elapsed++;
        end
      end
    endfunction

    function void clear_timer();
      elapsed = '0;
      prescaler = 0;
    endfunction

    function void run_phase(int temp, logic cont);
      int limit;
      limit = (step_count > mbps_pkg::MAX_STEPS) ? mbps_pkg::MAX_STEPS : int'(step_count);
      case (phase)
        mbps_pkg::PH_PREHEAT: begin
          setpoint = preheat_temp;
          if (cont) begin
            phase = mbps_pkg::PH_MASH;
            step = '0;
            reached = 1'b0;
            clear_timer();
          end
        end
        mbps_pkg::PH_MASH: begin
          if (reached) begin
            if (elapsed >= entry_dur[step]) begin
              reached = 1'b0;
              clear_timer();
              if (int'(step) + 1 < limit) step++;
              else phase = mbps_pkg::PH_BOIL;
            end
          end else if (temp >= 4 * int'(entry_temp[step])) begin
            reached = 1'b1;
            clear_timer();
          end
        end
        mbps_pkg::PH_BOIL: begin
          if (reached) begin
            if (elapsed >= boil_duration) phase = mbps_pkg::PH_COOL;
          end else if (temp < 4 * int'(boil_start_temp)) begin
            duty = mbps_pkg::DUTY_FULL;
          end else begin
            reached = 1'b1;
            clear_timer();
          end
        end
        default: ;
      endcase
      if (phase == mbps_pkg::PH_MASH) setpoint = entry_temp[step];
      else if (phase == mbps_pkg::PH_BOIL) setpoint = boil_start_temp;
    endfunction

    function void note_request(mbps_pkg::item_t r);
      status_t s;
      case (mbps_pkg::action_t'(r.action))
        mbps_pkg::ACT_TICK: begin
          advance_clock();
          run_phase($signed(r.temp_quarter), r.continue_req);
        end
        mbps_pkg::ACT_LOAD: begin
          if (r.entry_index < mbps_pkg::MAX_STEPS) begin
            entry_temp[r.entry_index] = r.entry_temp;
            entry_dur[r.entry_index] = r.entry_duration;
          end
        end
        mbps_pkg::ACT_DUTY: begin
          duty = (r.duty_value > mbps_pkg::DUTY_FULL) ? mbps_pkg::DUTY_FULL : r.duty_value;
        end
        default: ;
      endcase
      s = '{phase, step, relay, duty, setpoint, reached, elapsed, hours, minutes, seconds};
      expected_status.push_back(s);
    endfunction

    function string show(status_t s);
      return $sformatf({"phase %0d step %0d heater %0b duty %0d setpoint %0d",
                        " reached %0b elapsed %0d clock %0d:%0d:%0d"},
                       s.phase, s.step, s.heater, s.duty, s.setpoint, s.reached,
                       s.elapsed, s.hours, s.minutes, s.seconds);
    endfunction

    function void check_result(status_t got);
      status_t want;
      if (expected_status.size() == 0) begin
        if (mismatches < 10) $display("%0t: result with no request pending: %s", $time, show(got));
        mismatches++;
        return;
      end
      want = expected_status.pop_front();
      if (want != got) begin
        if (mismatches < 10) begin
          $display("%0t: mismatch", $time);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data;
  bit steady;
  process_scoreboard board;

  mbps_item_if item_bus();
  mbps_result_if result_bus();

  mash_boil_process_sequencer i_dut (
    .clk(clk),
    .rst(rst),
    .item(item_bus),
    .result(result_bus),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_bus.ready <= steady || ($urandom_range(0, 99) >= 16);
  end

  always @(posedge clk) begin : watch_results
    status_t got;
    if (!rst && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      got = '{result_bus.phase, result_bus.step_now, result_bus.heater_on,
              result_bus.heater_duty_now, result_bus.setpoint, result_bus.target_reached,
              result_bus.elapsed_units, result_bus.clock_hours, result_bus.clock_minutes,
              result_bus.clock_seconds};
      board.check_result(got);
    end
  end

  function automatic mbps_pkg::item_t rand_item();
    mbps_pkg::item_t r;
    r.action = 2'($urandom);
    r.temp_quarter = 10'($urandom);
    r.continue_req = 1'($urandom);
    r.entry_index = 3'($urandom);
    r.entry_temp = 7'($urandom);
    r.entry_duration = 8'($urandom);
    r.duty_value = 7'($urandom);
    return r;
  endfunction

  function automatic mbps_pkg::item_t mk_tick(logic signed [9:0] t, logic cont);
    mbps_pkg::item_t r;
    r = rand_item();
    r.action = mbps_pkg::ACT_TICK;
    r.temp_quarter = t;
    r.continue_req = cont;
    return r;
  endfunction

  function automatic mbps_pkg::item_t mk_load(logic [2:0] idx, logic [6:0] t, logic [7:0] d);
    mbps_pkg::item_t r;
    r = rand_item();
    r.action = mbps_pkg::ACT_LOAD;
    r.entry_index = idx;
    r.entry_temp = t;
    r.entry_duration = d;
    return r;
  endfunction

  function automatic mbps_pkg::item_t mk_duty(logic [6:0] v);
    mbps_pkg::item_t r;
    r = rand_item();
    r.action = mbps_pkg::ACT_DUTY;
    r.duty_value = v;
    return r;
  endfunction

  // Mostly hover around the current target so the steps get reached.
  function automatic logic signed [9:0] pick_temp();
    int target;
    int v;
    int unsigned dice;
    case (board.phase)
      mbps_pkg::PH_MASH: target = 4 * int'(board.entry_temp[board.step]);
      mbps_pkg::PH_BOIL: target = 4 * int'(board.boil_start_temp);
      default: target = 4 * int'(board.preheat_temp);
    endcase
    dice = $urandom_range(0, 99);
    if (dice < 15) return 10'($urandom);
    if (dice < 45) v = target - int'($urandom_range(1, 40));
    else v = target + int'($urandom_range(0, 12)) - 4;
    if (v > 511) v = 511;
    return 10'(v);
  endfunction

  function automatic mbps_pkg::item_t pick_item();
    mbps_pkg::item_t r;
    int unsigned dice;
    logic busy;
    r = rand_item();
    busy = (board.phase == mbps_pkg::PH_MASH) || (board.phase == mbps_pkg::PH_BOIL);
    dice = $urandom_range(0, 99);
    if (dice < 65) begin
      r.action = mbps_pkg::ACT_TICK;
      r.temp_quarter = pick_temp();
      if (board.phase == mbps_pkg::PH_PREHEAT) r.continue_req = 1'b0;
    end else if (dice < 78) begin
      r.action = mbps_pkg::ACT_DUTY;
    end else if (dice < 90) begin
      r.action = mbps_pkg::ACT_LOAD;
      // keep the run bounded: no new hold times, leave the running step alone
      if (busy) begin
        r.entry_duration = '0;
        if (r.entry_index == board.step) r.entry_index = 3'd7;
      end
    end else begin
      r.action = mbps_pkg::ACT_NONE;
    end
    return r;
  endfunction

  task automatic send_request(input mbps_pkg::item_t r);
    while (!steady && $urandom_range(0, 99) < 16) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.action <= r.action;
    item_bus.temp_quarter <= r.temp_quarter;
    item_bus.continue_req <= r.continue_req;
    item_bus.entry_index <= r.entry_index;
    item_bus.entry_temp <= r.entry_temp;
    item_bus.entry_duration <= r.entry_duration;
    item_bus.duty_value <= r.duty_value;
    @(posedge clk);
    while (item_bus.ready !== 1'b1) @(posedge clk);
    board.note_request(r);
  endtask

  task automatic mix(input int count);
    repeat (count) send_request(pick_item());
  endtask

  task automatic drain();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input mbps_pkg::cfg_reg_t idx, input logic [7:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.set_config(idx, data);
  endtask

  // Write only with the block idle: hold requests until every result is back.
  task automatic write_settings(input logic [7:0] count, input logic [7:0] preheat,
                                input logic [7:0] boil, input logic [7:0] preboil_len,
                                input logic [7:0] boil_start);
    drain();
    write_reg(mbps_pkg::CFG_STEP_COUNT, count);
    write_reg(mbps_pkg::CFG_PREHEAT_TEMP, preheat);
    write_reg(mbps_pkg::CFG_BOIL_DURATION, boil);
    write_reg(mbps_pkg::CFG_PREBOIL_DURATION, preboil_len);
    write_reg(mbps_pkg::CFG_BOIL_START_TEMP, boil_start);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    mbps_pkg::item_t r;
    int n;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_bus.valid = 1'b0;
    item_bus.action = '0;
    item_bus.temp_quarter = '0;
    item_bus.continue_req = 1'b0;
    item_bus.entry_index = '0;
    item_bus.entry_temp = '0;
    item_bus.entry_duration = '0;
    item_bus.duty_value = '0;
    result_bus.ready = 1'b0;
    steady = 1'b0;
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings, action codes, field extremes, ignored loads, duty saturation
    send_request(mk_tick(10'sd200, 1'b0));
    r = rand_item();
    r.action = mbps_pkg::ACT_NONE;
    send_request(r);
    send_request(mk_duty(7'd0));
    send_request(mk_duty(7'd100));
    send_request(mk_duty(7'd127));
    send_request(mk_duty(7'd101));
    send_request(mk_load(3'd6, 7'd127, 8'd255));
    send_request(mk_load(3'd7, 7'd0, 8'd0));
    send_request(mk_load(3'd0, 7'd0, 8'd0));
    send_request(mk_load(3'd1, 7'd100, 8'd255));
    send_request(mk_load(3'd2, 7'd127, 8'd128));
    send_request(mk_load(3'd3, 7'd64, 8'd1));
    send_request(mk_load(3'd4, 7'd1, 8'd127));
    send_request(mk_load(3'd5, 7'd50, 8'd0));
    send_request(mk_tick(-10'sd512, 1'b0));
    send_request(mk_tick(10'sd511, 1'b0));
    send_request(mk_tick(10'sd0, 1'b0));
    send_request(mk_tick(-10'sd220, 1'b0));
    send_request(mk_tick(10'sd500, 1'b0));
    send_request(mk_duty(7'd3));

    // preheat under several settings
    write_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    mix(50);
    write_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    mix(50);
    write_settings(8'($urandom), 8'($urandom_range(0, 100)), 8'($urandom), 8'($urandom),
                   8'($urandom_range(0, 100)));
    mix(50);

    // schedule: every step moves on as soon as its temperature is reached
    write_settings(8'($urandom_range(6, 7)), 8'($urandom), 8'd0, 8'($urandom),
                   8'($urandom_range(0, 100)));
    send_request(mk_load(3'd0, 7'($urandom_range(0, 100)), 8'd0));
    send_request(mk_load(3'd1, 7'd100, 8'd0));
    send_request(mk_load(3'd2, 7'd0, 8'd0));
    for (int i = 3; i < mbps_pkg::MAX_STEPS; i++)
      send_request(mk_load(3'(i), 7'($urandom_range(0, 100)), 8'd0));
    steady = 1'b1;
    send_request(mk_tick(pick_temp(), 1'b1));

    // mash and boil until cool or until 200 requests have been sent
    n = 0;
    while (board.phase != mbps_pkg::PH_COOL && n < 200) begin
      send_request(pick_item());
      n++;
      if (n % 50 == 0)
        write_settings(8'($urandom), 8'($urandom), 8'd0, 8'($urandom), 8'($urandom));
    end
    steady = 1'b0;

    mix(110);
    write_settings(8'd1, 8'd100, 8'd255, 8'd0, 8'd100);
    mix(110);

    drain();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.expected_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/mbps_pkg.sv
hdl/mbps_if.sv
hdl/mbps_cfg.sv
hdl/mbps_clock.sv
hdl/mbps_seq.sv
hdl/mash_boil_process_sequencer.sv
test/mash_boil_process_sequencer_test.sv
